// ===== hw/rtl/phtr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package phtr_pkg;
    localparam int MAX_TARGETS = 16;
    localparam int COORD_BITS = 16;
    localparam int ID_BITS = 8;
    localparam int IDX_BITS = $clog2(MAX_TARGETS);
    localparam int CNT_BITS = $clog2(MAX_TARGETS + 1);

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_POINTER = 2'd2;

    localparam logic [1:0] EV_DOWN = 2'd0;
    localparam logic [1:0] EV_MOVE = 2'd1;
    localparam logic [1:0] EV_UP = 2'd2;
    localparam logic [1:0] EV_CANCEL = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] event_kind;
        logic [COORD_BITS-1:0] pointer_x;
        logic [COORD_BITS-1:0] pointer_y;
        logic [ID_BITS-1:0] obj_id;
        logic [COORD_BITS-1:0] rect_left;
        logic [COORD_BITS-1:0] rect_top;
        logic [COORD_BITS-1:0] rect_width;
        logic [COORD_BITS-1:0] rect_height;
        logic signed [15:0] stack_order;
    } req_t;

    typedef struct packed {
        logic [ID_BITS-1:0] routed_id;
        logic routed_valid;
        logic capture_active;
        logic [ID_BITS-1:0] capture_id;
        logic [4:0] entry_count;
        logic [31:0] events_seen;
        logic table_full;
    } rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/phtr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface phtr_req_if;
    logic valid;
    logic ready;
    phtr_pkg::req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface phtr_rsp_if;
    logic valid;
    logic ready;
    phtr_pkg::rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/phtr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module phtr_queue (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic push,
    input wire phtr_pkg::req_t push_data,
    output logic full,
    input wire logic pop,
    output phtr_pkg::req_t pop_data,
    output logic empty
);
    phtr_pkg::req_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop && !empty)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push && !full) - 2'(pop && !empty);
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/phtr_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
module phtr_engine (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire phtr_pkg::req_t req,
    output logic busy,
    output logic done,
    output phtr_pkg::rsp_t rsp
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam int CB = phtr_pkg::COORD_BITS;
    localparam int IB = phtr_pkg::ID_BITS;
    localparam int XB = phtr_pkg::IDX_BITS;
    localparam int NB = phtr_pkg::CNT_BITS;

    logic [IB-1:0] ids_reg [phtr_pkg::MAX_TARGETS];
    logic [CB-1:0] left_reg [phtr_pkg::MAX_TARGETS];
    logic [CB-1:0] top_reg [phtr_pkg::MAX_TARGETS];
    logic [CB-1:0] wid_reg [phtr_pkg::MAX_TARGETS];
    logic [CB-1:0] hgt_reg [phtr_pkg::MAX_TARGETS];
    logic signed [15:0] ord_reg [phtr_pkg::MAX_TARGETS];

    logic [1:0] state_reg;
    phtr_pkg::req_t cur_reg;
    logic [NB-1:0] fill_reg;
    logic [NB-1:0] rd_reg;
    logic [NB-1:0] wr_reg;
    logic cap_reg;
    logic [IB-1:0] owner_reg;
    logic [31:0] events_reg;
    logic best_ok_reg;
    logic signed [15:0] best_ord_reg;
    logic [IB-1:0] best_id_reg;
    logic [IB-1:0] routed_reg;
    logic valid_reg;
    logic full_reg;

    logic [XB-1:0] ri;
    logic [XB-1:0] wi;
    logic hit;

    assign ri = rd_reg[XB-1:0];
    assign wi = wr_reg[XB-1:0];
    assign hit = (cur_reg.pointer_x >= left_reg[ri])
        && ({1'b0, cur_reg.pointer_x} <= {1'b0, left_reg[ri]} + {1'b0, wid_reg[ri]})
        && (cur_reg.pointer_y >= top_reg[ri])
        && ({1'b0, cur_reg.pointer_y} <= {1'b0, top_reg[ri]} + {1'b0, hgt_reg[ri]});

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);
    assign rsp.routed_id = routed_reg;
    assign rsp.routed_valid = valid_reg;
    assign rsp.capture_active = cap_reg;
    assign rsp.capture_id = cap_reg ? owner_reg : '0;
    assign rsp.entry_count = 5'(fill_reg);
    assign rsp.events_seen = events_reg;
    assign rsp.table_full = full_reg;

    // Table writes: appends at the fill level, compaction copies read slot to write slot.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start && req.req_type == phtr_pkg::REQ_ADD
            && fill_reg < NB'(phtr_pkg::MAX_TARGETS))
        begin
            ids_reg[fill_reg[XB-1:0]] <= req.obj_id;
            left_reg[fill_reg[XB-1:0]] <= req.rect_left;
            top_reg[fill_reg[XB-1:0]] <= req.rect_top;
            wid_reg[fill_reg[XB-1:0]] <= req.rect_width;
            hgt_reg[fill_reg[XB-1:0]] <= req.rect_height;
            ord_reg[fill_reg[XB-1:0]] <= req.stack_order;
        end
        else if (state_reg == ST_SCAN && cur_reg.req_type == phtr_pkg::REQ_REMOVE
                 && rd_reg < fill_reg && ids_reg[ri] != cur_reg.obj_id)
        begin
            ids_reg[wi] <= ids_reg[ri];
            left_reg[wi] <= left_reg[ri];
            top_reg[wi] <= top_reg[ri];
            wid_reg[wi] <= wid_reg[ri];
            hgt_reg[wi] <= hgt_reg[ri];
            ord_reg[wi] <= ord_reg[ri];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            cur_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg <= '0;
            rd_reg <= '0;
            wr_reg <= '0;
            cap_reg <= 1'b0;
            owner_reg <= '0;
            events_reg <= '0;
            best_ok_reg <= 1'b0;
            best_ord_reg <= '0;
            best_id_reg <= '0;
            routed_reg <= '0;
            valid_reg <= 1'b0;
            full_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        routed_reg <= '0;
                        valid_reg <= 1'b0;
                        full_reg <= 1'b0;
                        rd_reg <= '0;
                        wr_reg <= '0;
                        best_ok_reg <= 1'b0;
                        state_reg <= ST_DONE;
                        case (req.req_type)
                            phtr_pkg::REQ_ADD:
                            begin
                                if (fill_reg < NB'(phtr_pkg::MAX_TARGETS))
                                begin
                                    fill_reg <= fill_reg + 1'b1;
                                end
                                else
                                begin
                                    full_reg <= 1'b1;
                                end
                            end
                            phtr_pkg::REQ_REMOVE:
                            begin
                                state_reg <= ST_SCAN;
                            end
                            phtr_pkg::REQ_POINTER:
                            begin
                                events_reg <= events_reg + 32'd1;
                                if (req.event_kind == phtr_pkg::EV_CANCEL
                                    || cap_reg)
                                begin
                                    routed_reg <= cap_reg ? owner_reg : '0;
                                    valid_reg <= cap_reg;
                                    if (req.event_kind == phtr_pkg::EV_CANCEL
                                        || req.event_kind == phtr_pkg::EV_UP)
                                    begin
                                        cap_reg <= 1'b0;
                                        owner_reg <= '0;
                                    end
                                end
                                else
                                begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (rd_reg < fill_reg)
                    begin
                        rd_reg <= rd_reg + 1'b1;
                        if (cur_reg.req_type == phtr_pkg::REQ_REMOVE)
                        begin
                            if (ids_reg[ri] != cur_reg.obj_id)
                            begin
                                wr_reg <= wr_reg + 1'b1;
                            end
                        end
                        else if (hit && (!best_ok_reg || ord_reg[ri] > best_ord_reg))
                        begin
                            best_ok_reg <= 1'b1;
                            best_ord_reg <= ord_reg[ri];
                            best_id_reg <= ids_reg[ri];
                        end
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                        if (cur_reg.req_type == phtr_pkg::REQ_REMOVE)
                        begin
                            fill_reg <= wr_reg;
                        end
                        else if (best_ok_reg)
                        begin
                            routed_reg <= best_id_reg;
                            valid_reg <= 1'b1;
                            if (cur_reg.event_kind == phtr_pkg::EV_DOWN)
                            begin
                                cap_reg <= 1'b1;
                                owner_reg <= best_id_reg;
                            end
                        end
                    end
                end
                ST_DONE:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/pointer_hit_test_router_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Modport | Carries
// req_in   | sink    | req_type, event_kind, pointer, target id, rectangle, order
// rsp_out  | source  | routed id and valid, capture state, count, events, full flag
//
// Adds, cancels and captured events pass through the engine's idle and done states, then
// the result is held in the output register.
// Hit tests and removals walk the table one entry a cycle in the scan state before done.
// A two-item queue in front of the engine takes requests while the engine works.
// Reset clears the count, capture and event counter; table contents are left as they are.
// The engine holds its result in an output register and waits while rsp_out is stalled.
module pointer_hit_test_router_unit (
    input wire logic clk,
    input wire logic rst_n,
    phtr_req_if.sink req_in,
    phtr_rsp_if.source rsp_out
);
    phtr_pkg::req_t q_data;
    phtr_pkg::rsp_t eng_rsp;
    logic q_full, q_empty, eng_busy, eng_done, start;
    logic out_valid_reg;
    phtr_pkg::rsp_t out_reg;

    assign req_in.ready = !q_full;
    // The engine may start only when the output register is free for its result.
    assign start = !q_empty && !eng_busy && !out_valid_reg;

    phtr_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(req_in.valid),
        .push_data(req_in.payload),
        .full(q_full),
        .pop(start),
        .pop_data(q_data),
        .empty(q_empty)
    );

    phtr_engine u_engine (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .req(q_data),
        .busy(eng_busy),
        .done(eng_done),
        .rsp(eng_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (eng_done)
        begin
            out_reg <= eng_rsp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp_out.valid = out_valid_reg;
    assign rsp_out.payload = out_reg;
endmodule
`default_nettype wire

// ===== dv/phtr_checker.sv =====
`timescale 1ns / 1ps
module phtr_checker
    import phtr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    phtr_req_if         req_mon,
    phtr_rsp_if         rsp_mon,
    output int          fail_count,
    output int          pending,
    output int          adds_seen,
    output int          removes_seen,
    output int          pointer_seen,
    output int          routed_seen,
    output int          drops_seen
);
    // Predicted copy of the target table and the routing state.
    logic [ID_BITS-1:0]    tgt_id     [MAX_TARGETS];
    logic [COORD_BITS-1:0] tgt_left   [MAX_TARGETS];
    logic [COORD_BITS-1:0] tgt_top    [MAX_TARGETS];
    logic [COORD_BITS-1:0] tgt_width  [MAX_TARGETS];
    logic [COORD_BITS-1:0] tgt_height [MAX_TARGETS];
    logic signed [15:0]    tgt_order  [MAX_TARGETS];
    int                    tgt_count;
    logic                  held;
    logic [ID_BITS-1:0]    holder;
    logic [31:0]           dispatched;

    rsp_t expected_rsp_q[$];

    function automatic logic covers(int i, logic [COORD_BITS-1:0] px,
                                    logic [COORD_BITS-1:0] py);
        logic [COORD_BITS:0] right;
        logic [COORD_BITS:0] bottom;
        begin
            right  = {1'b0, tgt_left[i]} + {1'b0, tgt_width[i]};
            bottom = {1'b0, tgt_top[i]} + {1'b0, tgt_height[i]};
            return px >= tgt_left[i] && {1'b0, px} <= right &&
                   py >= tgt_top[i] && {1'b0, py} <= bottom;
        end
    endfunction

    function automatic rsp_t route_item(req_t r);
        rsp_t res;
        int   w;
        int   best;
        begin
            res = '0;
            case (r.req_type)
                REQ_ADD:
                begin
                    if (tgt_count < MAX_TARGETS)
                    begin
                        tgt_id[tgt_count]     = r.obj_id;
                        tgt_left[tgt_count]   = r.rect_left;
                        tgt_top[tgt_count]    = r.rect_top;
                        tgt_width[tgt_count]  = r.rect_width;
                        tgt_height[tgt_count] = r.rect_height;
                        tgt_order[tgt_count]  = r.stack_order;
                        tgt_count++;
                    end
                    else
                    begin
                        res.table_full = 1'b1;
                    end
                end
                REQ_REMOVE:
                begin
                    w = 0;
                    for (int i = 0; i < tgt_count; i++)
                    begin
                        if (tgt_id[i] != r.obj_id)
                        begin
                            tgt_id[w]     = tgt_id[i];
                            tgt_left[w]   = tgt_left[i];
                            tgt_top[w]    = tgt_top[i];
                            tgt_width[w]  = tgt_width[i];
                            tgt_height[w] = tgt_height[i];
                            tgt_order[w]  = tgt_order[i];
                            w++;
                        end
                    end
                    tgt_count = w;
                end
                REQ_POINTER:
                begin
                    dispatched++;
                    if (r.event_kind == EV_CANCEL)
                    begin
                        if (held)
                        begin
                            res.routed_id    = holder;
                            res.routed_valid = 1'b1;
                        end
                        held   = 1'b0;
                        holder = '0;
                    end
                    else if (held)
                    begin
                        res.routed_id    = holder;
                        res.routed_valid = 1'b1;
                        if (r.event_kind == EV_UP)
                        begin
                            held   = 1'b0;
                            holder = '0;
                        end
                    end
                    else
                    begin
                        best = -1;
                        for (int i = 0; i < tgt_count; i++)
                        begin
                            if (covers(i, r.pointer_x, r.pointer_y) &&
                                (best < 0 || tgt_order[i] > tgt_order[best]))
                                best = i;
                        end
                        if (best >= 0)
                        begin
                            res.routed_id    = tgt_id[best];
                            res.routed_valid = 1'b1;
                            if (r.event_kind == EV_DOWN)
                            begin
                                held   = 1'b1;
                                holder = tgt_id[best];
                            end
                        end
                    end
                end
                default: ;
            endcase
            res.capture_active = held;
            res.capture_id     = held ? holder : '0;
            res.entry_count    = 5'(tgt_count);
            res.events_seen    = dispatched;
            return res;
        end
    endfunction

    assign pending = expected_rsp_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_r;
        rsp_t got;
        if (!rst_n)
        begin
            tgt_count     = 0;
            held          = 1'b0;
            holder        = '0;
            dispatched    = '0;
            fail_count   <= 0;
            adds_seen    <= 0;
            removes_seen <= 0;
            pointer_seen <= 0;
            routed_seen  <= 0;
            drops_seen   <= 0;
            expected_rsp_q.delete();
        end
        else
        begin
            if (req_mon.valid && req_mon.ready)
            begin
                exp_r = route_item(req_mon.payload);
                expected_rsp_q = {expected_rsp_q, exp_r};
                adds_seen    <= adds_seen + (req_mon.payload.req_type == REQ_ADD);
                removes_seen <= removes_seen + (req_mon.payload.req_type == REQ_REMOVE);
                pointer_seen <= pointer_seen + (req_mon.payload.req_type == REQ_POINTER);
                routed_seen  <= routed_seen + exp_r.routed_valid;
                drops_seen   <= drops_seen + exp_r.table_full;
            end
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                got = rsp_mon.payload;
                if (expected_rsp_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR %0t: result with nothing expected: %p", $realtime, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_rsp_q.pop_front();
                    if (got.routed_id !== exp_r.routed_id ||
                        got.routed_valid !== exp_r.routed_valid ||
                        got.capture_active !== exp_r.capture_active ||
                        got.capture_id !== exp_r.capture_id ||
                        got.entry_count !== exp_r.entry_count ||
                        got.events_seen !== exp_r.events_seen ||
                        got.table_full !== exp_r.table_full)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("ERROR %0t: result mismatch", $realtime);
                            $display("  expected %p", exp_r);
                            $display("  actual   %p", got);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import phtr_pkg::*;

    localparam int NUM_RANDOM  = 1030;
    localparam int QUIET_TAIL  = 200;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;
    logic idle_on;
    logic hold_req;
    int   fail_count;
    int   pending;
    int   adds_seen;
    int   removes_seen;
    int   pointer_seen;
    int   routed_seen;
    int   drops_seen;
    int   quiet_cycles;

    phtr_req_if req_ch();
    phtr_rsp_if rsp_ch();

    pointer_hit_test_router_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_in  (req_ch),
        .rsp_out (rsp_ch)
    );

    phtr_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_mon      (req_ch),
        .rsp_mon      (rsp_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .adds_seen    (adds_seen),
        .removes_seen (removes_seen),
        .pointer_seen (pointer_seen),
        .routed_seen  (routed_seen),
        .drops_seen   (drops_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: nothing accepted for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic req_t mk_add(int id, int l, int t, int w, int h, int ord);
        req_t r;
        begin
            r             = '0;
            r.req_type    = REQ_ADD;
            r.obj_id      = ID_BITS'(id);
            r.rect_left   = COORD_BITS'(l);
            r.rect_top    = COORD_BITS'(t);
            r.rect_width  = COORD_BITS'(w);
            r.rect_height = COORD_BITS'(h);
            r.stack_order = 16'(ord);
            return r;
        end
    endfunction

    function automatic req_t mk_ptr(logic [1:0] kind, int x, int y);
        req_t r;
        begin
            r            = '0;
            r.req_type   = REQ_POINTER;
            r.event_kind = kind;
            r.pointer_x  = COORD_BITS'(x);
            r.pointer_y  = COORD_BITS'(y);
            return r;
        end
    endfunction

    function automatic req_t mk_rm(int id);
        req_t r;
        begin
            r          = '0;
            r.req_type = REQ_REMOVE;
            r.obj_id   = ID_BITS'(id);
            return r;
        end
    endfunction

    // Most items work on a small screen area with few ids, so that hits, ties,
    // removals and a full table are common; some carry fully random fields.
    function automatic req_t random_req();
        req_t r;
        int   pick;
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 7) == 0)
            begin
                r = $bits(req_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
                if (r.req_type == 2'd3 && $urandom_range(0, 3) != 0)
                    r.req_type = REQ_POINTER;
            end
            else if (pick < 34)
            begin
                r = mk_add($urandom_range(0, 6), $urandom_range(0, 250),
                           $urandom_range(0, 250), $urandom_range(0, 150),
                           $urandom_range(0, 150), $urandom_range(0, 8) - 4);
            end
            else if (pick < 42)
            begin
                r = mk_rm($urandom_range(0, 6));
            end
            else if (pick < 96)
            begin
                r = mk_ptr(2'($urandom), $urandom_range(0, 400), $urandom_range(0, 400));
            end
            else
            begin
                r          = $bits(req_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
                r.req_type = 2'd3;
            end
            return r;
        end
    endfunction

    task automatic send_req(req_t r);
        begin
            req_ch.valid   <= 1'b1;
            req_ch.payload <= r;
            do
                @(posedge clk);
            while (!req_ch.ready);
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
    endtask

    // Result side: random stall bursts, and one long hold-off on request.
    initial
    begin
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= (stall_left == 0);
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 9);
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        req_t directed[$];
        int   wait_cycles;
        quiet_cycles <= 0;
        idle_on <= 1'b1;
        hold_req <= 1'b0;
        rst_n <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = {directed, mk_ptr(EV_MOVE, 0, 0)};
        directed = {directed, mk_ptr(EV_CANCEL, 0, 0)};
        directed = {directed, req_t'{req_type: 2'd3, event_kind: 2'd3, default: '1}};
        directed = {directed, mk_add(10, 0, 0, 65535, 65535, -32768)};
        directed = {directed, mk_add(11, 65535, 65535, 65535, 65535, 32767)};
        directed = {directed, mk_add(12, 100, 100, 10, 10, 5)};
        directed = {directed, mk_add(13, 100, 100, 0, 0, 5)};
        directed = {directed, mk_ptr(EV_MOVE, 100, 100)};
        directed = {directed, mk_ptr(EV_MOVE, 65535, 65535)};
        directed = {directed, mk_ptr(EV_MOVE, 110, 110)};
        directed = {directed, mk_ptr(EV_MOVE, 111, 110)};
        directed = {directed, mk_ptr(EV_DOWN, 105, 105)};
        directed = {directed, mk_ptr(EV_MOVE, 0, 0)};
        // The capture owner is removed, but capture stays with it.
        directed = {directed, mk_rm(12)};
        directed = {directed, mk_ptr(EV_CANCEL, 5, 5)};
        directed = {directed, mk_ptr(EV_DOWN, 100, 100)};
        directed = {directed, mk_ptr(EV_UP, 3000, 3000)};
        directed = {directed, mk_ptr(EV_UP, 65535, 0)};
        directed = {directed, mk_add(255, 65535, 0, 0, 0, -1)};
        directed = {directed, mk_rm(0)};
        directed = {directed, mk_rm(10)};
        directed = {directed, mk_ptr(EV_DOWN, 5000, 5000)};
        directed = {directed, mk_ptr(EV_DOWN, 65535, 0)};
        directed = {directed, mk_ptr(EV_MOVE, 0, 65535)};
        foreach (directed[i])
            send_req(directed[i]);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            idle_on <= !((n >= 300 && n < 380) || n >= NUM_RANDOM - QUIET_TAIL);
            if (n == 450)
                hold_req <= 1'b1;
            send_req(random_req());
        end
        req_ch.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        wait_cycles = 0;
        while (wait_cycles < 40)
        begin
            @(posedge clk);
            wait_cycles++;
        end

        $display("Covered %0d adds (%0d dropped on a full table), %0d removals,",
                 adds_seen, drops_seen, removes_seen);
        $display("and %0d pointer events, %0d of them routed to a target.",
                 pointer_seen, routed_seen);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
